// ===== rtl/core/pcr_pkg.sv =====
// Shared types, constants and helper functions of the projected circle rasterizer.
package pcr_pkg;

  // Input word layout on in_tdata.
  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 48;

  // Divider sizing: magnitude of the numerator and of the depth.
  localparam int unsigned NUM_W     = 18;
  localparam int unsigned DEN_W     = 9;
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = DIV_CNT_W'(NUM_W - 1);

  // Register reset values.
  localparam logic [7:0]        FOCAL_RST = 8'd15;
  localparam logic [6:0]        SCX_RST   = 7'd64;
  localparam logic [7:0]        SCY_RST   = 8'd80;
  localparam logic signed [7:0] OFFX_RST  = 8'sd5;
  localparam logic signed [7:0] OFFY_RST  = 8'sd20;

  // Panel size for the in-view test.
  localparam logic signed [NUM_W-1:0] PANEL_W = NUM_W'(128);
  localparam logic signed [NUM_W-1:0] PANEL_H = NUM_W'(160);

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_FOCAL = 3'd0,
    CFG_SCX   = 3'd1,
    CFG_SCY   = 3'd2,
    CFG_OFFX  = 3'd3,
    CFG_OFFY  = 3'd4
  } pcr_cfg_e;

  // Input item kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // Plane codes.
  localparam logic [1:0] PLANE_XY = 2'd0;
  localparam logic [1:0] PLANE_YZ = 2'd1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULX,
    ST_DIVX_GO,
    ST_DIVX,
    ST_MULY,
    ST_DIVY_GO,
    ST_DIVY,
    ST_EMIT
  } pcr_state_t;

  // Circle parameters taken from a start word.
  typedef struct packed {
    logic signed [7:0] center_x;
    logic signed [7:0] center_y;
    logic signed [7:0] center_z;
    logic [6:0]        radius;
    logic [15:0]       color;
    logic [1:0]        plane;
  } pcr_load_t;

  // One world point of the current iteration.
  typedef struct packed {
    logic signed [9:0]       wx;
    logic signed [9:0]       wy;
    logic signed [DEN_W-1:0] wz;
  } pcr_point_t;

  // Saturate a projected coordinate to 16 bits.
  function automatic logic [15:0] sat16(input logic signed [NUM_W-1:0] v);
    logic [15:0] r;
    if (v > NUM_W'(32767)) begin
      r = 16'h7FFF;
    end else if (v < -NUM_W'(32768)) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/pcr_div.sv =====
// Shared one-bit-per-cycle signed divider with truncation toward zero.
module pcr_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [pcr_pkg::NUM_W-1:0]    num,
  input  logic signed [pcr_pkg::DEN_W-1:0]    den,
  output logic                                done,
  output logic signed [pcr_pkg::NUM_W-1:0]    quo
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [pcr_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [pcr_pkg::DEN_W-1:0]         rem_r, rem_nxt;
  logic [pcr_pkg::NUM_W-1:0]         nmag_r, nmag_nxt;
  logic [pcr_pkg::DEN_W-1:0]         dmag_r, dmag_nxt;
  logic                              neg_r, neg_nxt;
  logic                              zero_r, zero_nxt;
  logic signed [pcr_pkg::NUM_W-1:0]  quo_r, quo_nxt;
  logic [pcr_pkg::DEN_W:0]           trial;
  logic [pcr_pkg::DEN_W:0]           diff;
  logic                              qbit;
  logic [pcr_pkg::NUM_W-1:0]         qmag;

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold operands and partial results
  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    nmag_r <= nmag_nxt;
    dmag_r <= dmag_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
    quo_r  <= quo_nxt;
  end

  // Restoring step: shift in one numerator bit, subtract if it fits
  always_comb begin
    trial = {rem_r, nmag_r[pcr_pkg::NUM_W-1]};
    diff  = trial - {1'b0, dmag_r};
    qbit  = (trial >= {1'b0, dmag_r});
    qmag  = {nmag_r[pcr_pkg::NUM_W-2:0], qbit};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    nmag_nxt = nmag_r;
    dmag_nxt = dmag_r;
    neg_nxt  = neg_r;
    zero_nxt = zero_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = pcr_pkg::DIV_LAST_CNT;
      rem_nxt  = '0;
      nmag_nxt = num[pcr_pkg::NUM_W-1] ? pcr_pkg::NUM_W'(-num) : pcr_pkg::NUM_W'(num);
      dmag_nxt = den[pcr_pkg::DEN_W-1] ? pcr_pkg::DEN_W'(-den) : pcr_pkg::DEN_W'(den);
      neg_nxt  = num[pcr_pkg::NUM_W-1] ^ den[pcr_pkg::DEN_W-1];
      zero_nxt = (den == '0);
    end else if (busy_r) begin
      rem_nxt  = qbit ? diff[pcr_pkg::DEN_W-1:0] : trial[pcr_pkg::DEN_W-1:0];
      nmag_nxt = qmag;
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        // A zero depth gives a zero quotient
        if (zero_r) begin
          quo_nxt = '0;
        end else if (neg_r) begin
          quo_nxt = -$signed(qmag);
        end else begin
          quo_nxt = $signed(qmag);
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/core/pcr_circle.sv =====
// Midpoint circle state, iteration update and selection of the eight symmetric points.
module pcr_circle (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  pcr_pkg::pcr_load_t  ld,
  input  logic                step,
  input  logic [2:0]          pt_idx,
  output logic                active,
  output logic                final_step,
  output logic [15:0]         color,
  output pcr_pkg::pcr_point_t pt
);

  logic               active_r, active_nxt;
  logic signed [8:0]  run_x_r, run_x_nxt;
  logic signed [8:0]  run_y_r, run_y_nxt;
  logic [9:0]         dx_r, dx_nxt;
  logic [9:0]         dy_r, dy_nxt;
  logic signed [11:0] err_r, err_nxt;
  logic [7:0]         cur_x_r, cur_y_r;
  logic               fin_r;
  pcr_pkg::pcr_load_t held_r;

  logic signed [12:0] e0, e1, e2;
  logic signed [8:0]  x1, y1;
  logic [9:0]         dx1, dy1;
  logic               fin;

  logic [7:0]         u;
  logic [5:0]         vq;
  logic [7:0]         v;
  logic signed [8:0]  a0, a1, az;
  logic signed [9:0]  cx10, cy10;
  logic signed [8:0]  cz9;

  // Hold circle control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  // Hold iteration variables and circle parameters
  always_ff @(posedge clk) begin
    run_x_r <= run_x_nxt;
    run_y_r <= run_y_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    err_r   <= err_nxt;
    if (load) begin
      held_r <= ld;
    end
    if (step) begin
      cur_x_r <= run_x_r[7:0];
      cur_y_r <= run_y_r[7:0];
      fin_r   <= fin;
    end
  end

  // Midpoint update of one iteration
  always_comb begin
    e0  = {err_r[11], err_r};
    y1  = run_y_r;
    e1  = e0;
    dy1 = dy_r;
    if (e0 <= 13'sd0) begin
      y1  = run_y_r + 9'sd1;
      e1  = e0 + $signed({3'b000, dy_r});
      dy1 = dy_r + 10'd2;
    end
    x1  = run_x_r;
    dx1 = dx_r;
    e2  = e1;
    if (e1 > 13'sd0) begin
      x1  = run_x_r - 9'sd1;
      dx1 = dx_r + 10'd2;
      e2  = e1 + $signed({3'b000, dx1}) - $signed({5'b00000, held_r.radius, 1'b0});
    end
    fin = (x1 < y1);
  end

  // Load a circle or advance one iteration
  always_comb begin
    active_nxt = active_r;
    run_x_nxt  = run_x_r;
    run_y_nxt  = run_y_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    err_nxt    = err_r;
    if (load) begin
      run_x_nxt  = $signed({2'b00, ld.radius}) - 9'sd1;
      run_y_nxt  = '0;
      dx_nxt     = 10'd1;
      dy_nxt     = 10'd1;
      err_nxt    = 12'sd1 - $signed({4'b0000, ld.radius, 1'b0});
      active_nxt = (ld.radius != '0);
    end else if (step) begin
      run_x_nxt  = x1;
      run_y_nxt  = y1;
      dx_nxt     = dx1;
      dy_nxt     = dy1;
      err_nxt    = e2[11:0];
      active_nxt = !fin;
    end
  end

  // Pick the symmetric point for the current index
  always_comb begin
    cx10 = {{2{held_r.center_x[7]}}, held_r.center_x};
    cy10 = {{2{held_r.center_y[7]}}, held_r.center_y};
    cz9  = {held_r.center_z[7], held_r.center_z};
    vq   = pt_idx[2] ? 6'(cur_y_r >> 2) : 6'(cur_x_r >> 2);
    az   = pt_idx[1] ? -$signed({3'b000, vq}) : $signed({3'b000, vq});
    if (held_r.plane == pcr_pkg::PLANE_XY) begin
      u  = pt_idx[2] ? cur_y_r : cur_x_r;
      v  = pt_idx[2] ? cur_x_r : cur_y_r;
      a0 = pt_idx[1] ? -$signed({1'b0, u}) : $signed({1'b0, u});
      a1 = pt_idx[0] ? -$signed({1'b0, v}) : $signed({1'b0, v});
      pt.wx = cx10 + 10'(a0);
      pt.wy = cy10 + 10'(a1);
      pt.wz = cz9;
    end else begin
      u  = pt_idx[2] ? cur_x_r : cur_y_r;
      v  = '0;
      a0 = pt_idx[0] ? -$signed({1'b0, u}) : $signed({1'b0, u});
      a1 = az;
      if (held_r.plane == pcr_pkg::PLANE_YZ) begin
        pt.wx = cx10;
        pt.wy = cy10 + 10'(a0);
      end else begin
        pt.wx = cx10 + 10'(a0);
        pt.wy = cy10;
      end
      pt.wz = cz9 + a1 + 9'(v);
    end
  end

  assign active     = active_r;
  assign final_step = fin_r;
  assign color      = held_r.color;

endmodule

// ===== rtl/core/projected_circle_rasterizer.sv =====
// Top level: sequencer, shared multiplier, configuration registers and output register.
// A start word produces no output word; in_tready is high only when idle.
// While a circle is active, a step word yields eight output words, each point taking two
// multiply-divide passes (X, then Y) and one emit state; the next input word is taken after
// the eighth output word is emitted, plus any wait on out_tready.
// Reset (rst_n low) clears circle, sequencer, output valid; registers load 15, 64/80, 5/20.
module projected_circle_rasterizer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_addr,
  input  logic [7:0]                       cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // center_x[7:0], center_y[15:8], center_z[23:16], radius[30:24],
  // pixel_color[46:31], plane[48:47], zero fill[55:49]
  input  logic [pcr_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind[0]
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // screen_x[15:0], screen_y[31:16], out_color[47:32]
  output logic [pcr_pkg::OUT_DATA_W-1:0]   out_tdata,
  // in_view[0], circle_done[1]
  output logic [1:0]                       out_tuser,
  // last_of_step
  output logic                             out_tlast
);

  logic [7:0]        focal_r;
  logic [6:0]        scx_r;
  logic [7:0]        scy_r;
  logic signed [7:0] offx_r;
  logic signed [7:0] offy_r;

  pcr_pkg::pcr_state_t state_r, state_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic signed [pcr_pkg::NUM_W-1:0] mul_r, mul_nxt;
  logic signed [pcr_pkg::NUM_W-1:0] sx_r, sx_nxt;
  logic signed [pcr_pkg::NUM_W-1:0] sy_r, sy_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [pcr_pkg::OUT_DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [1:0]                        out_user_r, out_user_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                in_acc;
  logic                c_load, c_step, c_active, c_final;
  logic [15:0]         c_color;
  pcr_pkg::pcr_load_t  ld;
  pcr_pkg::pcr_point_t pt;

  logic                             div_start, div_done;
  logic signed [pcr_pkg::NUM_W-1:0] div_quo;
  logic signed [9:0]                coord;
  logic signed [pcr_pkg::NUM_W-1:0] coord_ext, focal_ext;
  logic                             view;

  // Unpack the input word
  always_comb begin
    ld.center_x = in_tdata[7:0];
    ld.center_y = in_tdata[15:8];
    ld.center_z = in_tdata[23:16];
    ld.radius   = in_tdata[30:24];
    ld.color    = in_tdata[46:31];
    ld.plane    = in_tdata[48:47];
  end

  assign in_tready = (state_r == pcr_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign c_load    = in_acc && (in_tuser == pcr_pkg::KIND_START);
  assign c_step    = in_acc && (in_tuser == pcr_pkg::KIND_STEP) && c_active;

  pcr_circle u_circle (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (c_load),
    .ld         (ld),
    .step       (c_step),
    .pt_idx     (idx_r),
    .active     (c_active),
    .final_step (c_final),
    .color      (c_color),
    .pt         (pt)
  );

  pcr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_r),
    .den   (pt.wz),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= pcr_pkg::FOCAL_RST;
      scx_r   <= pcr_pkg::SCX_RST;
      scy_r   <= pcr_pkg::SCY_RST;
      offx_r  <= pcr_pkg::OFFX_RST;
      offy_r  <= pcr_pkg::OFFY_RST;
    end else if (cfg_we) begin
      case (pcr_pkg::pcr_cfg_e'(cfg_addr))
        pcr_pkg::CFG_FOCAL: focal_r <= cfg_wdata;
        pcr_pkg::CFG_SCX:   scx_r   <= cfg_wdata[6:0];
        pcr_pkg::CFG_SCY:   scy_r   <= cfg_wdata;
        pcr_pkg::CFG_OFFX:  offx_r  <= cfg_wdata;
        pcr_pkg::CFG_OFFY:  offy_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold sequencer and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcr_pkg::ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold datapath and output payload
  always_ff @(posedge clk) begin
    mul_r      <= mul_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  // Shared multiplier: offset coordinate times focal scale
  always_comb begin
    if (state_r == pcr_pkg::ST_MULY) begin
      coord = pt.wy + 10'(offy_r);
    end else begin
      coord = pt.wx + 10'(offx_r);
    end
    coord_ext = pcr_pkg::NUM_W'(coord);
    focal_ext = $signed({10'b0, focal_r});
  end

  // In-view test on the unsaturated screen position, all compares signed
  assign view = ($signed(pt.wz) > pcr_pkg::DEN_W'(0))
             && (sx_r >= pcr_pkg::NUM_W'(0)) && (sx_r < pcr_pkg::PANEL_W)
             && (sy_r >= pcr_pkg::NUM_W'(0)) && (sy_r < pcr_pkg::PANEL_H);

  // Sequence the eight points of one step
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    mul_nxt       = mul_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    // Drop the output word once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pcr_pkg::ST_IDLE: begin
        if (c_step) begin
          idx_nxt   = '0;
          state_nxt = pcr_pkg::ST_MULX;
        end
      end
      pcr_pkg::ST_MULX: begin
        mul_nxt   = coord_ext * focal_ext;
        state_nxt = pcr_pkg::ST_DIVX_GO;
      end
      pcr_pkg::ST_DIVX_GO: begin
        div_start = 1'b1;
        state_nxt = pcr_pkg::ST_DIVX;
      end
      pcr_pkg::ST_DIVX: begin
        if (div_done) begin
          sx_nxt    = $signed({11'b0, scx_r}) + div_quo;
          state_nxt = pcr_pkg::ST_MULY;
        end
      end
      pcr_pkg::ST_MULY: begin
        mul_nxt   = coord_ext * focal_ext;
        state_nxt = pcr_pkg::ST_DIVY_GO;
      end
      pcr_pkg::ST_DIVY_GO: begin
        div_start = 1'b1;
        state_nxt = pcr_pkg::ST_DIVY;
      end
      pcr_pkg::ST_DIVY: begin
        if (div_done) begin
          sy_nxt    = $signed({10'b0, scy_r}) + div_quo;
          state_nxt = pcr_pkg::ST_EMIT;
        end
      end
      pcr_pkg::ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {c_color, pcr_pkg::sat16(sy_r), pcr_pkg::sat16(sx_r)};
          out_user_nxt  = {(idx_r == 3'd7) && c_final, view};
          out_last_nxt  = (idx_r == 3'd7);
          idx_nxt       = idx_r + 3'd1;
          state_nxt     = (idx_r == 3'd7) ? pcr_pkg::ST_IDLE : pcr_pkg::ST_MULX;
        end
      end
      default: begin
        state_nxt = pcr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/core/pcr_checker.sv =====
// Port-level checker for the projected circle rasterizer, bound to the top level.
module pcr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pcr_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [1:0]                       out_tuser,
  input logic                             out_tlast
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Circle done only on the last word of a step
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("circle_done without last_of_step");

  // A start word leaves the block ready
  a_start_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == pcr_pkg::KIND_START) |=> in_tready)
    else $error("not ready after a start word");

  // A visible point lies on the panel
  a_view_panel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[15:7] == 9'd0) && (out_tdata[31:16] < 16'd160))
    else $error("in_view set for a point off the panel");

  // Mid-step the block takes no input
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |-> !in_tready)
    else $error("input accepted in the middle of a step");

endmodule

bind projected_circle_rasterizer pcr_checker u_pcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
